@@ sv/rpe_pkg.sv @@
`default_nettype none
package rpe_pkg;

   localparam logic [3:0] TAG_AZIMUTH = 4'h8;
   localparam logic [3:0] TAG_RANGE   = 4'h3;
   localparam logic [3:0] TAG_HEIGHT  = 4'hC;

   localparam logic [1:0] CSR_RANGE_TOLERANCE  = 2'd0;
   localparam logic [1:0] CSR_MAX_ABSENCES     = 2'd1;
   localparam logic [1:0] CSR_MIN_TARGET_WIDTH = 2'd2;
   localparam logic [1:0] CSR_INHIBIT_RANGE    = 2'd3;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_PLOT   = 1'b1;

   localparam logic [15:0] AZ_LOW_LIMIT = 16'h8003;

   typedef struct packed {
      logic [15:0] start_range;
      logic [11:0] start_az;
      logic [7:0]  absences;
      logic [7:0]  height;
   } row_type;

   typedef struct packed {
      logic        item_kind;
      logic [3:0]  sector;
      logic [15:0] plot_azimuth;
      logic [15:0] plot_range;
      logic [7:0]  plot_height;
   } result_type;

endpackage
`default_nettype wire

@@ sv/radar_plot_extractor.sv @@
`default_nettype none
// Radar plot extractor. Request words carry a tag in the top nibble: azimuth, range or
// height. Open targets live in a single-port-read, single-port-write table memory of
// TABLE_DEPTH rows. A range word that closes a run, or a height word followed by a range
// word, walks the table once for the nearest entry, then writes at most one row. An
// in-sequence azimuth word optionally does that search, then walks the table again to
// age, close and compact entries, one row per cycle while no plot waits on a stalled
// result side. The one-row-per-cycle memory read port sets the walk length; no new
// word is taken until the walk ends and its results have left the hold. Other words
// need no table walk. Results of one word leave in order, the last one flagged.
module radar_plot_extractor #(
   parameter int TABLE_DEPTH   = 32,
   parameter int AZIMUTH_COUNT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_radar_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_item_kind,
   output logic [3:0]       rsp_sector,
   output logic [15:0]      rsp_plot_azimuth,
   output logic [15:0]      rsp_plot_range,
   output logic [7:0]       rsp_plot_height,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [11:0] HALF_AZ = 12'(AZIMUTH_COUNT / 2);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_AGE    = 2'd3;

   localparam logic [1:0] MODE_AZ     = 2'd0;
   localparam logic [1:0] MODE_RANGE  = 2'd1;
   localparam logic [1:0] MODE_HEIGHT = 2'd2;

   // table memory
   rpe_pkg::row_type tbl_mem [TABLE_DEPTH];
   rpe_pkg::row_type tbl_rd_ff;
   logic             tbl_we, tbl_re;
   logic [IW-1:0]    tbl_waddr, tbl_raddr;
   rpe_pkg::row_type tbl_wdata;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   logic [11:0] tol_ff, tol_in, minw_ff, minw_in, inhib_ff, inhib_in;
   logic [7:0]  maxabs_ff, maxabs_in;
   logic [15:0] last_az_ff, last_az_in;
   logic        resync_ff, resync_in, az_valid_ff, az_valid_in;
   logic [4:0]  prev_sector_ff, prev_sector_in;
   logic [3:0]  cur_sector_ff, cur_sector_in;
   logic        run_closed_ff, run_closed_in;
   logic [15:0] run_start_ff, run_start_in;
   logic [11:0] prev_az_ff, prev_az_in, az_new_ff, az_new_in;
   logic        hpend_ff, hpend_in;
   logic [7:0]  pheight_ff, pheight_in;
   logic [CW-1:0] count_ff, count_in;

   logic [1:0]    state_ff, state_in, mode_ff, mode_in;
   logic [15:0]   key_ff, key_in;
   logic [CW-1:0] iss_ff, iss_in, wr_ff, wr_in;
   logic          proc_valid_ff, proc_valid_in;
   logic [IW-1:0] proc_idx_ff, proc_idx_in;
   logic [15:0]   best_ff, best_in;
   logic          found_ff, found_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   rpe_pkg::row_type best_row_ff, best_row_in;

   rpe_pkg::result_type pend_ff, pend_in, rsp_ff, rsp_in;
   logic pend_valid_ff, pend_valid_in, pend_final_ff, pend_final_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;

   logic        accept, out_free, emit_now, hdr_now, finish_now, age_stall;
   logic [3:0]  tag;
   logic [16:0] az_limit;
   logic        az_ok;
   logic [15:0] range_gap;
   rpe_pkg::result_type emit_data, hdr_data;
   rpe_pkg::row_type    new_row;

   logic [7:0]         abs_inc;
   logic               close_now;
   logic signed [13:0] fin, inic, diff;
   logic signed [14:0] sum;
   logic [11:0]        mid_raw, mid;
   logic               wrap, wide_ok, sect_ok;
   logic [3:0]         cur_m1;

   assign req_stall = !(state_ff == ST_IDLE && !pend_valid_ff);
   assign accept    = req_valid && !req_stall;
   assign tag       = req_radar_word[15:12];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign az_limit  = {1'b0, last_az_ff} + 17'd4;
   assign az_ok     = ({1'b0, req_radar_word} < az_limit &&
                       (req_radar_word > last_az_ff || req_radar_word < rpe_pkg::AZ_LOW_LIMIT))
                      || resync_ff;
   assign range_gap = (key_ff >= tbl_rd_ff.start_range) ? key_ff - tbl_rd_ff.start_range
                                                        : tbl_rd_ff.start_range - key_ff;

   // closing arithmetic for the row in the read register
   assign abs_inc   = (tbl_rd_ff.absences == 8'hFF) ? 8'hFF : tbl_rd_ff.absences + 8'd1;
   assign close_now = abs_inc >= maxabs_ff;
   assign inic      = $signed({2'b00, tbl_rd_ff.start_az});
   assign fin       = $signed({2'b00, prev_az_ff}) - $signed({6'd0, maxabs_ff});
   assign wrap      = fin < inic;
   assign sum       = 15'(inic) + 15'(fin);
   assign mid_raw   = 12'(sum >>> 1);
   assign mid       = wrap ? mid_raw + HALF_AZ : mid_raw;
   assign diff      = fin - inic + (wrap ? 14'sd4096 : 14'sd0);
   assign wide_ok   = diff >= $signed({2'b00, minw_ff});
   assign cur_m1    = cur_sector_ff - 4'd1;
   assign sect_ok   = mid[11:8] == cur_sector_ff || mid[11:8] == cur_m1;
   assign emit_now  = state_ff == ST_AGE && proc_valid_ff && close_now && wide_ok && sect_ok;
   assign age_stall = emit_now && pend_valid_ff && !out_free;

   always_comb begin
      emit_data.item_kind    = rpe_pkg::KIND_PLOT;
      emit_data.sector       = 4'd0;
      emit_data.plot_azimuth = {4'b1000, mid};
      emit_data.plot_range   = tbl_rd_ff.start_range;
      emit_data.plot_height  = tbl_rd_ff.height;
      hdr_data.item_kind     = rpe_pkg::KIND_HEADER;
      hdr_data.sector        = req_radar_word[11:8];
      hdr_data.plot_azimuth  = 16'd0;
      hdr_data.plot_range    = 16'd0;
      hdr_data.plot_height   = 8'd0;
      new_row.start_range    = key_ff;
      new_row.start_az       = prev_az_ff;
      new_row.absences       = 8'd0;
      new_row.height         = 8'd0;
   end

   always_comb begin
      tol_in = tol_ff; maxabs_in = maxabs_ff; minw_in = minw_ff; inhib_in = inhib_ff;
      last_az_in = last_az_ff; resync_in = resync_ff; az_valid_in = az_valid_ff;
      prev_sector_in = prev_sector_ff; cur_sector_in = cur_sector_ff;
      run_closed_in = run_closed_ff; run_start_in = run_start_ff;
      prev_az_in = prev_az_ff; az_new_in = az_new_ff;
      hpend_in = hpend_ff; pheight_in = pheight_ff; count_in = count_ff;
      state_in = state_ff; mode_in = mode_ff; key_in = key_ff;
      iss_in = iss_ff; wr_in = wr_ff; proc_valid_in = proc_valid_ff; proc_idx_in = proc_idx_ff;
      best_in = best_ff; found_in = found_ff; best_idx_in = best_idx_ff;
      best_row_in = best_row_ff;
      hdr_now = 1'b0; finish_now = 1'b0;
      tbl_we = 1'b0; tbl_re = 1'b0;
      tbl_waddr = wr_ff[IW-1:0]; tbl_raddr = iss_ff[IW-1:0];
      tbl_wdata = new_row;

      if (csr_write) begin
         case (csr_index)
            rpe_pkg::CSR_RANGE_TOLERANCE:  tol_in    = csr_wdata;
            rpe_pkg::CSR_MAX_ABSENCES:     maxabs_in = csr_wdata[7:0];
            rpe_pkg::CSR_MIN_TARGET_WIDTH: minw_in   = csr_wdata;
            rpe_pkg::CSR_INHIBIT_RANGE:    inhib_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            iss_in = '0; wr_in = '0; proc_valid_in = 1'b0;
            best_in = {5'd0, tol_ff[11:1]} + 16'd1; found_in = 1'b0;
            if (accept) begin
               case (tag)
                  rpe_pkg::TAG_AZIMUTH: begin
                     hpend_in = 1'b0;
                     if (az_ok) begin
                        resync_in = 1'b0; last_az_in = req_radar_word; az_valid_in = 1'b1;
                        cur_sector_in = req_radar_word[11:8];
                        az_new_in = req_radar_word[11:0];
                        if ({1'b0, req_radar_word[11:8]} != prev_sector_ff) begin
                           prev_sector_in = {1'b0, req_radar_word[11:8]};
                           hdr_now = 1'b1;
                        end
                        run_closed_in = 1'b1;
                        if (!run_closed_ff) begin
                           key_in = run_start_ff; mode_in = MODE_AZ; state_in = ST_SEARCH;
                        end else begin
                           prev_az_in = req_radar_word[11:0]; state_in = ST_AGE;
                        end
                     end else begin
                        resync_in = 1'b1;
                        if (req_radar_word == last_az_ff) begin
                           az_valid_in = 1'b0;
                        end else begin
                           count_in = '0;
                        end
                     end
                  end
                  rpe_pkg::TAG_RANGE: begin
                     if (req_radar_word[11:0] >= inhib_ff) begin
                        if (hpend_ff) begin
                           hpend_in = 1'b0; run_closed_in = 1'b1;
                           key_in = req_radar_word; mode_in = MODE_HEIGHT;
                           state_in = ST_SEARCH;
                        end else if (az_valid_ff) begin
                           if (run_closed_ff) begin
                              run_start_in = req_radar_word; run_closed_in = 1'b0;
                           end else if (req_radar_word > run_start_ff &&
                                        req_radar_word - run_start_ff > {4'd0, tol_ff}) begin
                              key_in = run_start_ff; mode_in = MODE_RANGE;
                              state_in = ST_SEARCH; run_start_in = req_radar_word;
                           end
                        end
                     end
                  end
                  rpe_pkg::TAG_HEIGHT: begin
                     hpend_in = 1'b1; pheight_in = req_radar_word[7:0];
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            tbl_re = iss_ff < count_ff;
            proc_valid_in = iss_ff < count_ff;
            proc_idx_in = iss_ff[IW-1:0];
            if (iss_ff < count_ff) begin
               iss_in = iss_ff + CW'(1);
            end
            if (proc_valid_ff && range_gap < best_ff) begin
               best_in = range_gap; found_in = 1'b1;
               best_idx_in = proc_idx_ff; best_row_in = tbl_rd_ff;
            end
            if (iss_ff == count_ff && !proc_valid_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            tbl_wdata = best_row_ff;
            if (mode_ff == MODE_HEIGHT) begin
               tbl_wdata.height = pheight_ff;
               tbl_waddr = best_idx_ff;
               tbl_we = found_ff;
            end else if (found_ff) begin
               tbl_wdata.absences = 8'd0;
               tbl_waddr = best_idx_ff;
               tbl_we = 1'b1;
            end else if (count_ff < DEPTH_C) begin
               tbl_wdata = new_row;
               tbl_waddr = count_ff[IW-1:0];
               tbl_we = 1'b1;
               count_in = count_ff + CW'(1);
            end
            iss_in = '0; wr_in = '0; proc_valid_in = 1'b0;
            if (mode_ff == MODE_AZ) begin
               prev_az_in = az_new_ff; state_in = ST_AGE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_AGE: begin
            if (!age_stall) begin
               tbl_re = iss_ff < count_ff;
               proc_valid_in = iss_ff < count_ff;
               if (iss_ff < count_ff) begin
                  iss_in = iss_ff + CW'(1);
               end
               if (proc_valid_ff && !close_now) begin
                  tbl_wdata = tbl_rd_ff;
                  tbl_wdata.absences = abs_inc;
                  tbl_we = 1'b1;
                  wr_in = wr_ff + CW'(1);
               end
               if (iss_ff == count_ff && !proc_valid_ff) begin
                  count_in = wr_ff; finish_now = 1'b1; state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // one-deep hold so the last flag can be set once the walk ends
   always_comb begin
      pend_in = pend_ff; pend_valid_in = pend_valid_ff; pend_final_in = pend_final_ff;
      rsp_in = rsp_ff; rsp_last_in = rsp_last_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      if (pend_valid_ff && out_free && (pend_final_ff || emit_now)) begin
         rsp_in = pend_ff; rsp_last_in = pend_final_ff; rsp_valid_in = 1'b1;
         pend_valid_in = 1'b0;
      end
      if (emit_now && !age_stall) begin
         pend_in = emit_data; pend_valid_in = 1'b1; pend_final_in = 1'b0;
      end
      if (hdr_now) begin
         pend_in = hdr_data; pend_valid_in = 1'b1; pend_final_in = 1'b0;
      end
      if (finish_now) begin
         pend_final_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 12'd4; maxabs_ff <= 8'd3; minw_ff <= 12'd2; inhib_ff <= 12'd13;
         last_az_ff <= '0; resync_ff <= 1'b1; az_valid_ff <= 1'b0;
         prev_sector_ff <= 5'd16; cur_sector_ff <= '0; run_closed_ff <= 1'b1;
         run_start_ff <= '0; prev_az_ff <= '0; hpend_ff <= 1'b0; pheight_ff <= '0;
         count_ff <= '0; state_ff <= ST_IDLE; iss_ff <= '0; wr_ff <= '0;
         proc_valid_ff <= 1'b0; pend_valid_ff <= 1'b0; pend_final_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tol_ff <= tol_in; maxabs_ff <= maxabs_in; minw_ff <= minw_in; inhib_ff <= inhib_in;
         last_az_ff <= last_az_in; resync_ff <= resync_in; az_valid_ff <= az_valid_in;
         prev_sector_ff <= prev_sector_in; cur_sector_ff <= cur_sector_in;
         run_closed_ff <= run_closed_in; run_start_ff <= run_start_in;
         prev_az_ff <= prev_az_in; hpend_ff <= hpend_in; pheight_ff <= pheight_in;
         count_ff <= count_in; state_ff <= state_in; iss_ff <= iss_in; wr_ff <= wr_in;
         proc_valid_ff <= proc_valid_in; pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in; rsp_valid_ff <= rsp_valid_in;
      end
      az_new_ff <= az_new_in; mode_ff <= mode_in; key_ff <= key_in;
      proc_idx_ff <= proc_idx_in; best_ff <= best_in; found_ff <= found_in;
      best_idx_ff <= best_idx_in; best_row_ff <= best_row_in;
      pend_ff <= pend_in; rsp_ff <= rsp_in; rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item_kind    = rsp_ff.item_kind;
   assign rsp_sector       = rsp_ff.sector;
   assign rsp_plot_azimuth = rsp_ff.plot_azimuth;
   assign rsp_plot_range   = rsp_ff.plot_range;
   assign rsp_plot_height  = rsp_ff.plot_height;
   assign rsp_last         = rsp_last_ff;

endmodule
`default_nettype wire

@@ sv/rpe_checker.sv @@
`default_nettype none
module rpe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_item_kind,
   input wire logic [3:0]  rsp_sector,
   input wire logic [15:0] rsp_plot_azimuth,
   input wire logic [15:0] rsp_plot_range,
   input wire logic [7:0]  rsp_plot_height,
   input wire logic        rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_plot_azimuth) && $stable(rsp_last))
      else $error("stalled result changed");

   // more results of this request are still queued, so no new request
   a_no_accept_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request accepted before last result");

   a_plot_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == rpe_pkg::KIND_PLOT |->
         rsp_plot_azimuth[15] && rsp_sector == 4'd0)
      else $error("plot azimuth flag missing");

   a_header_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == rpe_pkg::KIND_HEADER |->
         rsp_plot_azimuth == 16'd0 && rsp_plot_range == 16'd0 && rsp_plot_height == 8'd0)
      else $error("header carries plot fields");

endmodule

bind radar_plot_extractor rpe_checker u_rpe_checker (.*);
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
module tb;

   localparam int DEPTH = 32;
   localparam int WATCH_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_radar_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_kind;
   logic [3:0]  rsp_sector;
   logic [15:0] rsp_plot_azimuth;
   logic [15:0] rsp_plot_range;
   logic [7:0]  rsp_plot_height;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_wdata = '0;

   radar_plot_extractor dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct packed {
      rpe_pkg::result_type r;
      logic                last;
   } plot_item_type;

   // predictor state
   logic [11:0] m_tol, m_minw, m_inhib;
   logic [7:0]  m_maxabs;
   logic [15:0] m_lastaz;
   bit          m_resync, m_azvalid, m_runclosed, m_hpend;
   int unsigned m_prevsect, m_cursect;
   logic [15:0] m_runstart;
   logic [11:0] m_prevaz;
   logic [7:0]  m_hgt;
   rpe_pkg::row_type m_rows[DEPTH];
   int unsigned m_count;

   plot_item_type expected_q[$];
   logic [15:0]   word_q[$];
   int            errors = 0;
   int            mismatches = 0;
   int unsigned   idle_cycles = 0;
   int            tx_wait = 0, rx_wait = 0;
   bit            hold = 0;

   function automatic int find_nearest(logic [15:0] rng);
      int unsigned half, best, d, a;
      int found;
      half = m_tol >> 1;
      best = half + 1;
      found = -1;
      for (int j = 0; j < m_count; j++) begin
         a = m_rows[j].start_range;
         d = (rng >= a) ? rng - a : a - rng;
         if (best > d) begin
            best = d;
            found = j;
         end
      end
      if (found >= 0 && best <= half) return found;
      return -1;
   endfunction

   task automatic add_result(logic kind, logic [3:0] s, logic [15:0] az,
                             logic [15:0] rg, logic [7:0] h, ref plot_item_type res[$]);
      plot_item_type p;
      p.r.item_kind = kind;
      p.r.sector = s;
      p.r.plot_azimuth = az;
      p.r.plot_range = rg;
      p.r.plot_height = h;
      p.last = 1'b0;
      if (res.size() < 33) res.push_back(p);
   endtask

   task automatic correlate_run();
      int k;
      k = find_nearest(m_runstart);
      if (k >= 0) m_rows[k].absences = 0;
      else if (m_count < DEPTH) begin
         m_rows[m_count].start_range = m_runstart;
         m_rows[m_count].start_az = m_prevaz;
         m_rows[m_count].absences = 0;
         m_rows[m_count].height = 0;
         m_count++;
      end
   endtask

   task automatic predict_word(logic [15:0] w);
      plot_item_type res[$];
      int unsigned j, s, sect, prv, mid;
      int inic, fin, k;
      if (w[15:12] == rpe_pkg::TAG_AZIMUTH) begin
         m_hpend = 0;
         if ((int'(w) < int'(m_lastaz) + 4 && (w > m_lastaz || w < rpe_pkg::AZ_LOW_LIMIT))
             || m_resync) begin
            m_resync = 0;
            m_lastaz = w;
            m_azvalid = 1;
            s = w[11:8];
            m_cursect = s;
            if (s != m_prevsect) begin
               m_prevsect = s;
               add_result(rpe_pkg::KIND_HEADER, s[3:0], 0, 0, 0, res);
            end
            if (!m_runclosed) correlate_run();
            m_runclosed = 1;
            m_prevaz = w[11:0];
            j = 0;
            while (j < m_count) begin
               if (m_rows[j].absences < 255) m_rows[j].absences++;
               if (m_rows[j].absences >= m_maxabs) begin
                  inic = int'(m_rows[j].start_az);
                  fin = int'(m_prevaz) - int'(m_maxabs);
                  mid = (inic + fin + 8192) >> 1;
                  if (fin < inic) begin
                     mid = (mid + 2048) & 12'hfff;
                     fin += 4096;
                  end else mid = (mid - 4096) & 12'hfff;
                  if (fin - inic >= int'(m_minw)) begin
                     mid |= 16'h8000;
                     sect = (mid >> 8) & 4'hf;
                     prv = (m_cursect - 1) & 4'hf;
                     if (sect == m_cursect || sect == prv)
                        add_result(rpe_pkg::KIND_PLOT, 0, mid[15:0], m_rows[j].start_range,
                                   m_rows[j].height, res);
                  end
                  for (int i = j; i + 1 < m_count; i++) m_rows[i] = m_rows[i + 1];
                  m_count--;
               end else j++;
            end
         end else begin
            m_resync = 1;
            if (w == m_lastaz) m_azvalid = 0;
            else m_count = 0;
         end
      end else if (w[15:12] == rpe_pkg::TAG_RANGE) begin
         if (w[11:0] >= m_inhib) begin
            if (m_hpend) begin
               m_hpend = 0;
               m_runclosed = 1;
               k = find_nearest(w);
               if (k >= 0) m_rows[k].height = m_hgt;
            end else if (m_azvalid) begin
               if (m_runclosed) begin
                  m_runstart = w;
                  m_runclosed = 0;
               end else if (w > m_runstart && int'(w - m_runstart) > int'(m_tol)) begin
                  correlate_run();
                  m_runstart = w;
               end
            end
         end
      end else if (w[15:12] == rpe_pkg::TAG_HEIGHT) begin
         m_hpend = 1;
         m_hgt = w[7:0];
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      foreach (res[i]) expected_q.push_back(res[i]);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         predict_word(req_radar_word);
         void'(word_q.pop_front());
         tx_wait = $urandom_range(0, 9);
         if (tx_wait == 0 && !hold && word_q.size() > 0) begin
            req_radar_word <= word_q[0];
         end else req_valid <= 1'b0;
      end else if (!req_valid) begin
         if (tx_wait > 0) tx_wait--;
         else if (!hold && word_q.size() > 0) begin
            req_valid <= 1'b1;
            req_radar_word <= word_q[0];
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      plot_item_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected result kind=%0d", rsp_item_kind);
            end else begin
               e = expected_q.pop_front();
               if (e.r.item_kind !== rsp_item_kind || e.r.sector !== rsp_sector ||
                   e.r.plot_azimuth !== rsp_plot_azimuth ||
                   e.r.plot_range !== rsp_plot_range ||
                   e.r.plot_height !== rsp_plot_height || e.last !== rsp_last) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch exp %0d/%h/%h/%h/%h/%0d got %0d/%h/%h/%h/%h/%0d",
                              e.r.item_kind, e.r.sector, e.r.plot_azimuth,
                              e.r.plot_range, e.r.plot_height, e.last,
                              rsp_item_kind, rsp_sector, rsp_plot_azimuth,
                              rsp_plot_range, rsp_plot_height, rsp_last);
               end
            end
            rx_wait = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) rx_wait = 0;
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic set_reg(logic [1:0] idx, logic [11:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         rpe_pkg::CSR_RANGE_TOLERANCE:  m_tol = v;
         rpe_pkg::CSR_MAX_ABSENCES:     m_maxabs = v[7:0];
         rpe_pkg::CSR_MIN_TARGET_WIDTH: m_minw = v;
         rpe_pkg::CSR_INHIBIT_RANGE:    m_inhib = v;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (word_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clock);
      repeat (2 * DEPTH + 20) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_word();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 5) return 16'($urandom_range(0, 16'hffff));
      if (p < 10) return {rpe_pkg::TAG_HEIGHT, 4'h0, 8'($urandom)};
      return {rpe_pkg::TAG_RANGE, 12'($urandom_range(0, 600))};
   endfunction

   // sweeps of azimuths with range runs
   task automatic queue_sweep(int n);
      logic [11:0] az;
      int r;
      az = 12'($urandom);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 30) == 0) begin
            word_q.push_back({rpe_pkg::TAG_AZIMUTH, 12'($urandom)});
         end else begin
            az = az + 12'($urandom_range(0, 2) == 0 ? 2 : 1);
            word_q.push_back({rpe_pkg::TAG_AZIMUTH, az});
         end
         r = $urandom_range(0, 3);
         for (int k = 0; k < r; k++) word_q.push_back(rand_word());
      end
   endtask

   initial begin
      m_tol = 4; m_maxabs = 3; m_minw = 2; m_inhib = 13;
      m_lastaz = 0; m_resync = 1; m_azvalid = 0; m_prevsect = 16; m_cursect = 0;
      m_runclosed = 1; m_runstart = 0; m_prevaz = 0; m_hpend = 0; m_hgt = 0;
      m_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, wrap, height, resync, ignored tags
      word_q = '{16'h8ffc, 16'h3fff, 16'h300d, 16'h300c, 16'hc0ff, 16'h3fff,
                 16'h8ffd, 16'h3010, 16'h3012, 16'h3030, 16'h8ffe, 16'h8fff,
                 16'h8000, 16'h8001, 16'h8001, 16'h8001, 16'h8005, 16'h8100,
                 16'h0000, 16'hffff, 16'h7fff, 16'h3000, 16'h8101, 16'h8102,
                 16'h8103};
      drain();
      set_reg(rpe_pkg::CSR_RANGE_TOLERANCE, 12'hfff);
      set_reg(rpe_pkg::CSR_MAX_ABSENCES, 12'd255);
      set_reg(rpe_pkg::CSR_MIN_TARGET_WIDTH, 12'd0);
      set_reg(rpe_pkg::CSR_INHIBIT_RANGE, 12'd0);
      queue_sweep(40);
      drain();
      set_reg(rpe_pkg::CSR_MAX_ABSENCES, 12'd0);
      set_reg(rpe_pkg::CSR_RANGE_TOLERANCE, 12'd0);
      set_reg(rpe_pkg::CSR_MIN_TARGET_WIDTH, 12'hfff);
      set_reg(rpe_pkg::CSR_INHIBIT_RANGE, 12'hfff);
      queue_sweep(20);
      drain();
      set_reg(rpe_pkg::CSR_RANGE_TOLERANCE, 12'd6);
      set_reg(rpe_pkg::CSR_MAX_ABSENCES, 12'd2);
      set_reg(rpe_pkg::CSR_MIN_TARGET_WIDTH, 12'd1);
      set_reg(rpe_pkg::CSR_INHIBIT_RANGE, 12'd13);
      queue_sweep(40);
      queue_sweep(40);
      while (word_q.size() >= 50) @(posedge clock);
      // pause until all results are in
      hold = 1;
      while (req_valid || expected_q.size() > 0) @(posedge clock);
      repeat (2 * DEPTH + 20) @(posedge clock);
      hold = 0;
      drain();
      set_reg(rpe_pkg::CSR_RANGE_TOLERANCE, 12'd40);
      set_reg(rpe_pkg::CSR_MAX_ABSENCES, 12'd5);
      set_reg(rpe_pkg::CSR_MIN_TARGET_WIDTH, 12'd3);
      queue_sweep(40);
      drain();
      if (errors == 0 && expected_q.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
